@@ src/bspl_pkg.sv @@
// Shared widths, payload types and unit interfaces for the cubic B-spline evaluator.
package bspl_pkg;

   // Coordinate and step widths.
   localparam int COORD_BITS  = 12;
   localparam int STEP_BITS   = 10;
   localparam int STEPS_RESET = 100;

   // Weights and the denominator 6*s^3 stay below 2^(3*STEP_BITS+3).
   localparam int W_BITS     = 3 * STEP_BITS + 3;
   // Second multiplier operand: a coordinate, one of k, s and v, or the small factor 6s-3k.
   localparam int MUL_B_BITS = (COORD_BITS > STEP_BITS + 4) ? COORD_BITS : STEP_BITS + 4;
   localparam int PROD_BITS  = W_BITS + MUL_B_BITS + 1;
   // Signed weighted sum of four coordinates.
   localparam int ACC_BITS   = W_BITS + COORD_BITS + 1;
   // Offset dividend of the rounding division, always non-negative.
   localparam int NUM_BITS   = W_BITS + COORD_BITS + 2;
   localparam int DIV_CNT_BITS = $clog2(COORD_BITS);

   // Command codes.
   localparam logic CMD_PUSH   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic                         cmd;
      logic signed [COORD_BITS-1:0] in_x;
      logic signed [COORD_BITS-1:0] in_y;
      logic [STEP_BITS-1:0]         step_index;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
      logic                         window_full;
   } rsp_type;

   // Request to the shared divider.
   typedef struct packed {
      logic                       start;
      logic signed [ACC_BITS-1:0] num;
      logic [W_BITS-1:0]          den;
   } div_req_type;

   // Answer of the shared divider.
   typedef struct packed {
      logic                         done;
      logic signed [COORD_BITS-1:0] quot;
   } div_rsp_type;

endpackage

@@ src/cubic_bspline_point_evaluator.sv @@
// Top level of the uniform cubic B-spline point evaluator: window, sequencer and output stage.
//
// Usage: items enter on req_valid/req_stall. A push item (cmd 0) shifts a control
// point into a four-point window; it gives no result and leaves the block ready.
// A sample item (cmd 1) gives one result on rsp_valid/rsp_stall: the curve point
// at t = step_index / steps, step_index capped at steps, rounded half up, with window_full
// set. With fewer than four points held the result is zero with window_full clear.
// A full sample works out the weights and the two weighted sums on the one shared
// multiplier, then runs two 12-bit rounding divisions on the shared one-bit-a-cycle
// divider. req_stall is high while a sample is being worked on, so samples run
// one at a time. The result sits in an output register; the next item is accepted
// while it waits, and a finished sample waits there for rsp_stall to fall before
// it is handed over. Write steps through csr_we/csr_wdata only while the block
// is idle; the block itself does not enforce this. Zero acts as one.
// Synchronous reset empties the window, sets steps to 100 and drops rsp_valid.
module cubic_bspline_point_evaluator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bspl_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bspl_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [bspl_pkg::STEP_BITS-1:0] csr_wdata
);
   import bspl_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_MUL       = 3'd1;
   localparam logic [2:0] ST_DIVX_GO   = 3'd2;
   localparam logic [2:0] ST_DIVX_WAIT = 3'd3;
   localparam logic [2:0] ST_DIVY_GO   = 3'd4;
   localparam logic [2:0] ST_DIVY_WAIT = 3'd5;
   localparam logic [2:0] ST_DONE      = 3'd6;

   localparam logic [3:0] PH_LAST      = 4'd15;
   localparam logic [2:0] WINDOW_DEPTH = 3'd4;
   localparam int         M_BITS       = STEP_BITS + 3;

   logic [2:0]                   state_ff, state_in;
   logic [3:0]                   ph_ff, ph_in;
   logic [STEP_BITS-1:0]         steps_ff, steps_in;
   logic [2:0]                   held_ff, held_in;
   logic signed [COORD_BITS-1:0] win_x_ff [4];
   logic signed [COORD_BITS-1:0] win_x_in [4];
   logic signed [COORD_BITS-1:0] win_y_ff [4];
   logic signed [COORD_BITS-1:0] win_y_in [4];
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [STEP_BITS-1:0]         k_ff, k_in, s_ff, s_in, v_ff, v_in;
   logic [2*STEP_BITS-1:0]       k2_ff, k2_in, s2_ff, s2_in, v2_ff, v2_in;
   logic [3*STEP_BITS-1:0]       s3_ff, s3_in;
   logic [W_BITS-1:0]            den_ff, den_in;
   logic [W_BITS-1:0]            w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in, w3_ff, w3_in;
   logic signed [ACC_BITS-1:0]   acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [COORD_BITS-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic                         full_ff, full_in;
   rsp_type                      rsp_data_ff, rsp_data_in;

   logic                         req_acc;
   logic                         out_free;
   logic [STEP_BITS-1:0]         s_eff;
   logic [STEP_BITS-1:0]         k_sat;
   logic [M_BITS-1:0]            m63;
   logic [W_BITS-1:0]            s3_w;
   logic [W_BITS-1:0]            prod_w;
   logic signed [ACC_BITS-1:0]   prod_acc;

   logic [W_BITS-1:0]            mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  prod_ff;
   div_req_type                  div_req;
   div_rsp_type                  div_rsp;

   bspl_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   bspl_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Handshakes.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Effective step count and saturated sample position.
   assign s_eff = (steps_ff == '0) ? STEP_BITS'(1) : steps_ff;
   assign k_sat = (req_data.step_index > s_eff) ? s_eff : req_data.step_index;

   // Small factor 6s - 3k, always positive since k <= s.
   assign m63 = (M_BITS'(s_ff) << 2) + (M_BITS'(s_ff) << 1)
              - (M_BITS'(k_ff) << 1) - M_BITS'(k_ff);

   assign s3_w     = W_BITS'(s3_ff);
   assign prod_w   = prod_ff[W_BITS-1:0];
   assign prod_acc = signed'(prod_ff[ACC_BITS-1:0]);

   // Multiplier operands for each phase of the sequence.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (ph_ff)
         4'd0: begin
            mul_a = W_BITS'(k_ff);
            mul_b = signed'(MUL_B_BITS'(k_ff));
         end
         4'd1: begin
            mul_a = W_BITS'(s_ff);
            mul_b = signed'(MUL_B_BITS'(s_ff));
         end
         4'd2: begin
            mul_a = W_BITS'(v_ff);
            mul_b = signed'(MUL_B_BITS'(v_ff));
         end
         4'd3: begin
            mul_a = W_BITS'(k2_ff);
            mul_b = signed'(MUL_B_BITS'(k_ff));
         end
         4'd4: begin
            mul_a = W_BITS'(s2_ff);
            mul_b = signed'(MUL_B_BITS'(s_ff));
         end
         4'd5: begin
            mul_a = W_BITS'(v2_ff);
            mul_b = signed'(MUL_B_BITS'(v_ff));
         end
         4'd6: begin
            mul_a = W_BITS'(k2_ff);
            mul_b = signed'(MUL_B_BITS'(m63));
         end
         4'd7: begin
            mul_a = w0_ff;
            mul_b = MUL_B_BITS'(win_x_ff[0]);
         end
         4'd8: begin
            mul_a = w1_ff;
            mul_b = MUL_B_BITS'(win_x_ff[1]);
         end
         4'd9: begin
            mul_a = w2_ff;
            mul_b = MUL_B_BITS'(win_x_ff[2]);
         end
         4'd10: begin
            mul_a = w3_ff;
            mul_b = MUL_B_BITS'(win_x_ff[3]);
         end
         4'd11: begin
            mul_a = w0_ff;
            mul_b = MUL_B_BITS'(win_y_ff[0]);
         end
         4'd12: begin
            mul_a = w1_ff;
            mul_b = MUL_B_BITS'(win_y_ff[1]);
         end
         4'd13: begin
            mul_a = w2_ff;
            mul_b = MUL_B_BITS'(win_y_ff[2]);
         end
         4'd14: begin
            mul_a = w3_ff;
            mul_b = MUL_B_BITS'(win_y_ff[3]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Divider requests in the two start states.
   assign div_req.start = (state_ff == ST_DIVX_GO) || (state_ff == ST_DIVY_GO);
   assign div_req.num   = (state_ff == ST_DIVY_GO) ? acc_y_ff : acc_x_ff;
   assign div_req.den   = den_ff;

   // Sequencer and data path registers.
   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      steps_in     = steps_ff;
      held_in      = held_ff;
      win_x_in     = win_x_ff;
      win_y_in     = win_y_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      k_in         = k_ff;
      s_in         = s_ff;
      v_in         = v_ff;
      k2_in        = k2_ff;
      s2_in        = s2_ff;
      v2_in        = v2_ff;
      s3_in        = s3_ff;
      den_in       = den_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      w3_in        = w3_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      full_in      = full_ff;

      if (csr_we) begin
         steps_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_data.cmd == CMD_PUSH) begin
                  // Shift the window, newest point at the top.
                  win_x_in[0] = win_x_ff[1];
                  win_x_in[1] = win_x_ff[2];
                  win_x_in[2] = win_x_ff[3];
                  win_x_in[3] = req_data.in_x;
                  win_y_in[0] = win_y_ff[1];
                  win_y_in[1] = win_y_ff[2];
                  win_y_in[2] = win_y_ff[3];
                  win_y_in[3] = req_data.in_y;
                  if (held_ff != WINDOW_DEPTH) begin
                     held_in = held_ff + 3'd1;
                  end
               end else if (held_ff != WINDOW_DEPTH) begin
                  // Not enough points: a zero result.
                  rx_in    = '0;
                  ry_in    = '0;
                  full_in  = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  k_in     = k_sat;
                  s_in     = s_eff;
                  v_in     = s_eff - k_sat;
                  ph_in    = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // The product of the previous phase is consumed here.
            unique case (ph_ff)
               4'd1:  k2_in = prod_w[2*STEP_BITS-1:0];
               4'd2:  s2_in = prod_w[2*STEP_BITS-1:0];
               4'd3:  v2_in = prod_w[2*STEP_BITS-1:0];
               4'd4:  w3_in = prod_w;
               4'd5:  s3_in = prod_w[3*STEP_BITS-1:0];
               4'd6: begin
                  w0_in  = prod_w;
                  den_in = (s3_w << 2) + (s3_w << 1);
               end
               4'd7: begin
                  // w1 = 4s^3 - k^2(6s-3k); w2 = 6s^3 - w0 - w1 - w3.
                  w1_in = (s3_w << 2) - prod_w;
                  w2_in = (s3_w << 1) - w0_ff - w3_ff + prod_w;
               end
               4'd8:  acc_x_in = prod_acc;
               4'd9,
               4'd10,
               4'd11: acc_x_in = acc_x_ff + prod_acc;
               4'd12: acc_y_in = prod_acc;
               4'd13,
               4'd14,
               4'd15: acc_y_in = acc_y_ff + prod_acc;
               default: begin
               end
            endcase
            ph_in = ph_ff + 4'd1;
            if (ph_ff == PH_LAST) begin
               state_in = ST_DIVX_GO;
            end
         end
         ST_DIVX_GO: begin
            state_in = ST_DIVX_WAIT;
         end
         ST_DIVX_WAIT: begin
            if (div_rsp.done) begin
               rx_in    = div_rsp.quot;
               state_in = ST_DIVY_GO;
            end
         end
         ST_DIVY_GO: begin
            state_in = ST_DIVY_WAIT;
         end
         ST_DIVY_WAIT: begin
            if (div_rsp.done) begin
               ry_in    = div_rsp.quot;
               full_in  = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand the result to the output register once it is free.
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_x       = rx_ff;
               rsp_data_in.out_y       = ry_ff;
               rsp_data_in.window_full = full_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= '0;
         steps_ff     <= STEP_BITS'(STEPS_RESET);
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            win_x_ff[i] <= '0;
            win_y_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         steps_ff     <= steps_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         win_x_ff     <= win_x_in;
         win_y_ff     <= win_y_in;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      k_ff        <= k_in;
      s_ff        <= s_in;
      v_ff        <= v_in;
      k2_ff       <= k2_in;
      s2_ff       <= s2_in;
      v2_ff       <= v2_in;
      s3_ff       <= s3_in;
      den_ff      <= den_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      w3_ff       <= w3_in;
      acc_x_ff    <= acc_x_in;
      acc_y_ff    <= acc_y_in;
      rx_ff       <= rx_in;
      ry_ff       <= ry_in;
      full_ff     <= full_in;
   end

endmodule

@@ src/bspl_mul.sv @@
// Shared signed multiplier with a registered product.
module bspl_mul (
   input  logic                                  clock,
   input  logic [bspl_pkg::W_BITS-1:0]           mul_a,
   input  logic signed [bspl_pkg::MUL_B_BITS-1:0] mul_b,
   output logic signed [bspl_pkg::PROD_BITS-1:0]  prod_ff
);
   import bspl_pkg::*;

   logic signed [W_BITS:0]      a_s;
   logic signed [PROD_BITS-1:0] prod_in;

   // The first operand is always non-negative.
   assign a_s     = signed'({1'b0, mul_a});
   assign prod_in = PROD_BITS'(a_s) * PROD_BITS'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

@@ src/bspl_div.sv @@
// Restoring divider that rounds a weighted sum to the nearest coordinate, one bit a cycle.
module bspl_div (
   input  logic                    clock,
   input  logic                    reset,
   input  bspl_pkg::div_req_type   div_req,
   output bspl_pkg::div_rsp_type   div_rsp
);
   import bspl_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0]     rem_ff, rem_in;
   logic [NUM_BITS-1:0]     dsh_ff, dsh_in;
   logic [COORD_BITS-1:0]   quot_ff, quot_in;

   logic [NUM_BITS-1:0] num_ext;
   logic [NUM_BITS-1:0] den_ext;
   logic [NUM_BITS-1:0] start_rem;
   logic                ge;

   // Dividend 2*num + den, shifted up by 2^COORD_BITS * den so that it is never
   // negative; the quotient then carries an offset of half the coordinate range.
   assign num_ext   = {{(NUM_BITS-ACC_BITS){div_req.num[ACC_BITS-1]}}, div_req.num};
   assign den_ext   = NUM_BITS'(div_req.den);
   assign start_rem = (num_ext << 1) + den_ext + (den_ext << COORD_BITS);
   assign ge        = (rem_ff >= dsh_ff);

   // One trial subtraction per cycle, most significant quotient bit first.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      priority if (div_req.start) begin
         busy_in = 1'b1;
         rem_in  = start_rem;
         dsh_in  = den_ext << COORD_BITS;
         cnt_in  = DIV_CNT_BITS'(COORD_BITS - 1);
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quot_in = {quot_ff[COORD_BITS-2:0], ge};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         // Idle: the last quotient is held.
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   // Removing the offset flips the top bit of the quotient.
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = signed'({~quot_ff[COORD_BITS-1], quot_ff[COORD_BITS-2:0]});

endmodule

@@ src/bspl_chk.sv @@
// Port-level checks for the cubic B-spline evaluator and their binding to the top level.
module bspl_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input bspl_pkg::req_type              req_data,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input bspl_pkg::rsp_type              rsp_data
);
   import bspl_pkg::*;

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   // A sample item occupies the block in the following cycle.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd == CMD_SAMPLE |=> req_stall)
      else $error("block ready right after a sample item");

   // A push item leaves the block ready in the following cycle.
   a_push_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.cmd == CMD_PUSH |=> !req_stall)
      else $error("block busy after a push item");

   // A result from a partly filled window is zero.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.window_full |-> rsp_data.out_x == '0 && rsp_data.out_y == '0)
      else $error("nonzero result without a full window");

endmodule

bind cubic_bspline_point_evaluator bspl_chk u_bspl_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

@@ sim/cubic_bspline_point_evaluator_tb.sv @@
// Self-checking testbench for the cubic B-spline point evaluator.
module cubic_bspline_point_evaluator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bspl_pkg::*;

   localparam int NUM_DIRECTED     = 26;
   localparam int NUM_PHASES       = 9;
   localparam int ITEMS_PER_PHASE  = 92;
   localparam int DRAIN_CYCLES     = 8;
   localparam int TAIL_CYCLES      = 60;
   localparam int LONG_HOLD_AT     = 620;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT      = 4000;

   // One row of the directed stimulus; a typed row carries its own answer.
   typedef struct {
      logic cmd;
      int   px;
      int   py;
      int   k;
      bit   typed;
      int   want_x;
      int   want_y;
      bit   want_full;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [STEP_BITS-1:0] csr_wdata = '0;

   // Shadow copy of the control point window and the steps register.
   logic signed [COORD_BITS-1:0] ctl_x [4];
   logic signed [COORD_BITS-1:0] ctl_y [4];
   int ctl_count = 0;
   logic [STEP_BITS-1:0] steps_shadow = STEP_BITS'(STEPS_RESET);

   // Curve points still owed by the block, oldest first.
   rsp_type curve_points_due [$];

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int mismatch_count = 0;
   int pushes_sent = 0;
   int samples_sent = 0;
   int full_samples = 0;
   int points_checked = 0;
   int quiet_cycles = 0;
   int req_seen = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;

   // Steps per phase; a negative entry draws a random value.
   int steps_plan [NUM_PHASES] = '{1, 1023, 0, -1, 3, 1023, -1, 1, -1};

   stim_row_type directed_rows [NUM_DIRECTED] = '{
      '{CMD_SAMPLE,     0,     0,    0, 1,     0,     0, 0},
      '{CMD_PUSH,    2047, -2048, 1023, 0,     0,     0, 0},
      '{CMD_SAMPLE,    -1,    -1,    5, 1,     0,     0, 0},
      '{CMD_PUSH,    2047, -2048,    0, 0,     0,     0, 0},
      '{CMD_PUSH,    2047, -2048,  512, 0,     0,     0, 0},
      '{CMD_SAMPLE,     0,     0,  100, 1,     0,     0, 0},
      '{CMD_PUSH,    2047, -2048,    0, 0,     0,     0, 0},
      '{CMD_SAMPLE,     0,     0,    0, 1,  2047, -2048, 1},
      '{CMD_SAMPLE,     0,     0,  100, 1,  2047, -2048, 1},
      '{CMD_SAMPLE, -2048,  2047, 1023, 1,  2047, -2048, 1},
      '{CMD_PUSH,   -2048,  2047,    0, 0,     0,     0, 0},
      '{CMD_SAMPLE,     0,     0,    0, 0,     0,     0, 0},
      '{CMD_SAMPLE,     0,     0,   37, 0,     0,     0, 0},
      '{CMD_PUSH,       0,     0,    0, 0,     0,     0, 0},
      '{CMD_PUSH,      -1,     1,    0, 0,     0,     0, 0},
      '{CMD_SAMPLE,     0,     0,    1, 0,     0,     0, 0},
      '{CMD_PUSH,       1,    -1,    0, 0,     0,     0, 0},
      '{CMD_SAMPLE,     0,     0,   50, 0,     0,     0, 0},
      '{CMD_SAMPLE,     0,     0,   99, 0,     0,     0, 0},
      '{CMD_SAMPLE,     0,     0,  100, 0,     0,     0, 0},
      '{CMD_SAMPLE,     0,     0, 1023, 0,     0,     0, 0},
      '{CMD_PUSH,   -2048,  2047, 1023, 0,     0,     0, 0},
      '{CMD_PUSH,   -2048,  2047,    0, 0,     0,     0, 0},
      '{CMD_PUSH,   -2048,  2047, 1023, 0,     0,     0, 0},
      '{CMD_PUSH,   -2048,  2047,    0, 0,     0,     0, 0},
      '{CMD_SAMPLE,  1365, -1366,   77, 1, -2048,  2047, 1}
   };

   cubic_bspline_point_evaluator i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < 4; i++) begin
         ctl_x[i] = '0;
         ctl_y[i] = '0;
      end
   end

   // Weighted sum over 6*s^3, rounded half up with a floor division.
   function automatic logic signed [COORD_BITS-1:0] round_blend(
      input logic signed [COORD_BITS-1:0] p [4], input longint w [4], input longint den);
      longint num;
      longint q;
      num = w[0] * p[0] + w[1] * p[1] + w[2] * p[2] + w[3] * p[3];
      num = 2 * num + den;
      q = num / (2 * den);
      if ((num % (2 * den)) != 0 && num < 0) begin
         q = q - 1;
      end
      return q[COORD_BITS-1:0];
   endfunction

   // Curve point the block should give for a sample at step k_in.
   function automatic rsp_type predict_curve_point(input logic [STEP_BITS-1:0] k_in);
      rsp_type pt;
      longint s;
      longint k;
      longint w [4];
      longint den;
      pt = '0;
      if (ctl_count < 4) begin
         return pt;
      end
      s = steps_shadow;
      if (s == 0) begin
         s = 1;
      end
      k = k_in;
      if (k > s) begin
         k = s;
      end
      w[0] = (s - k) * (s - k) * (s - k);
      w[1] = 3 * k * k * k - 6 * k * k * s + 4 * s * s * s;
      w[2] = -3 * k * k * k + 3 * k * k * s + 3 * k * s * s + s * s * s;
      w[3] = k * k * k;
      den = 6 * s * s * s;
      pt.out_x = round_blend(ctl_x, w, den);
      pt.out_y = round_blend(ctl_y, w, den);
      pt.window_full = 1'b1;
      return pt;
   endfunction

   // Coordinates lean toward the corners of the range now and then.
   function automatic logic signed [COORD_BITS-1:0] random_coord();
      logic [31:0] r;
      r = $urandom;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: return COORD_BITS'(-(2 ** (COORD_BITS - 1)));
            1: return COORD_BITS'(2 ** (COORD_BITS - 1) - 1);
            2: return '0;
            default: return '1;
         endcase
      end
      return r[COORD_BITS-1:0];
   endfunction

   // Random item: mostly samples within the segment, some at its ends or beyond.
   function automatic req_type random_item();
      req_type it;
      logic [31:0] r;
      int s_eff;
      int pick;
      s_eff = (steps_shadow == 0) ? 1 : int'(steps_shadow);
      it.cmd = ($urandom_range(0, 99) < 40) ? CMD_PUSH : CMD_SAMPLE;
      it.in_x = random_coord();
      it.in_y = random_coord();
      pick = $urandom_range(0, 9);
      r = $urandom;
      if (pick < 6) begin
         it.step_index = STEP_BITS'($urandom_range(0, s_eff));
      end else if (pick == 6) begin
         it.step_index = '0;
      end else if (pick == 7) begin
         it.step_index = STEP_BITS'(s_eff);
      end else begin
         it.step_index = r[STEP_BITS-1:0];
      end
      return it;
   endfunction

   // Offers one item, waits for it to be taken, then updates the shadow state.
   task automatic send_item(input req_type it, input bit typed, input rsp_type typed_rsp);
      rsp_type due;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      if (it.cmd == CMD_SAMPLE) begin
         due = predict_curve_point(it.step_index);
         if (typed) begin
            due = typed_rsp;
         end
         full_samples += (ctl_count >= 4);
         samples_sent++;
         curve_points_due.push_back(due);
      end else begin
         for (int i = 0; i < 3; i++) begin
            ctl_x[i] = ctl_x[i + 1];
            ctl_y[i] = ctl_y[i + 1];
         end
         ctl_x[3] = it.in_x;
         ctl_y[3] = it.in_y;
         if (ctl_count < 4) begin
            ctl_count++;
         end
         pushes_sent++;
      end
   endtask

   // Stops offering items and waits until every owed curve point has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (curve_points_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic flag_mismatch(input string field, input int got, input int want);
      $display("%0t: %s mismatch: got %0d, want %0d", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // Result receiver: random stalls, plus one long hold-off that backs the block up.
   always @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_seen++;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!long_hold_done && req_seen >= LONG_HOLD_AT) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // Result checker and watchdog on cycles without any handshake.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (curve_points_due.size() == 0) begin
            flag_mismatch("unexpected result, out_x", rsp_data.out_x, 0);
         end else begin
            want = curve_points_due.pop_front();
            points_checked++;
            if (rsp_data.out_x !== want.out_x) begin
               flag_mismatch("out_x", rsp_data.out_x, want.out_x);
            end
            if (rsp_data.out_y !== want.out_y) begin
               flag_mismatch("out_y", rsp_data.out_y, want.out_y);
            end
            if (rsp_data.window_full !== want.window_full) begin
               flag_mismatch("window_full", rsp_data.window_full, want.window_full);
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: %0d cycles without a handshake", QUIET_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Stimulus: directed rows at the reset steps value, then random phases.
   initial begin
      req_type it;
      rsp_type typed_rsp;
      stim_row_type row;
      int s_next;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 8;
      rsp_idle_pct = 56;
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = directed_rows[i];
         it.cmd = row.cmd;
         it.in_x = row.px[COORD_BITS-1:0];
         it.in_y = row.py[COORD_BITS-1:0];
         it.step_index = row.k[STEP_BITS-1:0];
         typed_rsp.out_x = row.want_x[COORD_BITS-1:0];
         typed_rsp.out_y = row.want_y[COORD_BITS-1:0];
         typed_rsp.window_full = row.want_full;
         send_item(it, row.typed, typed_rsp);
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         // Swap who idles a third of the way in, and stop idling for the last third.
         if (ph == NUM_PHASES / 3) begin
            send_idle_pct = 56;
            rsp_idle_pct = 8;
         end else if (ph == 2 * NUM_PHASES / 3) begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         // The steps register is only written once the block has gone quiet.
         wait_drained();
         s_next = (steps_plan[ph] < 0) ? $urandom_range(2, 1022) : steps_plan[ph];
         csr_we <= 1'b1;
         csr_wdata <= s_next[STEP_BITS-1:0];
         @(posedge clock);
         csr_we <= 1'b0;
         steps_shadow = s_next[STEP_BITS-1:0];
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_item(random_item(), 1'b0, '0);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run covered %0d pushes and %0d samples, %0d of them on a full window,",
               pushes_sent, samples_sent, full_samples);
      $display("over %0d steps settings including 0, 1 and 1023; %0d points checked",
               NUM_PHASES + 1, points_checked);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/bspl_pkg.sv
src/bspl_mul.sv
src/bspl_div.sv
src/cubic_bspline_point_evaluator.sv
src/bspl_chk.sv
sim/cubic_bspline_point_evaluator_tb.sv
